// ===== rtl/cover_actuator_power_sequencer_assert.svh =====
// assertion macros for the cover actuator power sequencer
`ifndef COVER_ACTUATOR_POWER_SEQUENCER_ASSERT_SVH
`define COVER_ACTUATOR_POWER_SEQUENCER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CAS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define CAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define CAS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CAS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/cas_pkg.sv =====
// shared types and constants of the cover actuator power sequencer
`timescale 1ns / 1ps
`default_nettype none
package cas_pkg;

   typedef logic [31:0] time_type;
   typedef logic [30:0] dur_type;
   typedef logic [15:0] code_type;
   typedef logic [2:0]  csr_index_type;
   typedef logic [30:0] csr_data_type;
   typedef logic [2:0]  status_type;
   typedef logic [2:0]  phase_code_type;

   // register indexes
   localparam csr_index_type CSR_REST_TIME    = 3'd0;
   localparam csr_index_type CSR_UNCOVER_TIME = 3'd1;
   localparam csr_index_type CSR_COVER_TIME   = 3'd2;
   localparam csr_index_type CSR_MOVE_TIME    = 3'd3;
   localparam csr_index_type CSR_COVER_CODE   = 3'd4;
   localparam csr_index_type CSR_UNCOVER_CODE = 3'd5;

   // register reset values
   localparam dur_type  REST_TIME_RESET    = 31'd2000000;
   localparam dur_type  UNCOVER_TIME_RESET = 31'd4000000;
   localparam dur_type  COVER_TIME_RESET   = 31'd8000000;
   localparam dur_type  MOVE_TIME_RESET    = 31'd45000000;
   localparam code_type CODE_RESET         = 16'd0;

   // reported cover status
   localparam status_type STATUS_UNKNOWN = 3'd0;
   localparam status_type STATUS_CLOSING = 3'd1;
   localparam status_type STATUS_OPENING = 3'd2;
   localparam status_type STATUS_CLOSED  = 3'd3;
   localparam status_type STATUS_OPENED  = 3'd4;

   // reported phase
   localparam phase_code_type PHASE_CODE_IDLE  = 3'd0;
   localparam phase_code_type PHASE_CODE_REST1 = 3'd1;
   localparam phase_code_type PHASE_CODE_DRIVE = 3'd2;
   localparam phase_code_type PHASE_CODE_REST2 = 3'd3;
   localparam phase_code_type PHASE_CODE_MOVE  = 3'd4;

   typedef enum logic [4:0] {
      PHASE_IDLE  = 5'b00001,
      PHASE_REST1 = 5'b00010,
      PHASE_DRIVE = 5'b00100,
      PHASE_REST2 = 5'b01000,
      PHASE_MOVE  = 5'b10000
   } phase_type;

   typedef struct packed {
      dur_type  rest_time;
      dur_type  uncover_time;
      dur_type  cover_time;
      dur_type  move_time;
      code_type cover_code;
      code_type uncover_code;
   } cfg_type;

   typedef struct packed {
      time_type now;
      logic     request_valid;
      logic     want_cover;
      code_type request_code;
   } req_item_type;

   typedef struct packed {
      logic           power_on;
      status_type     cover_status;
      phase_code_type phase;
   } rsp_item_type;

   function automatic phase_code_type phase_code(input phase_type p);
      phase_code_type c;
      case (p)
         PHASE_IDLE:  c = PHASE_CODE_IDLE;
         PHASE_REST1: c = PHASE_CODE_REST1;
         PHASE_DRIVE: c = PHASE_CODE_DRIVE;
         PHASE_REST2: c = PHASE_CODE_REST2;
         PHASE_MOVE:  c = PHASE_CODE_MOVE;
         default:     c = PHASE_CODE_IDLE;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/cas_req_if.sv =====
// request channel of the cover actuator power sequencer
`timescale 1ns / 1ps
`default_nettype none
interface cas_req_if;
   logic              valid;
   logic              ready;
   cas_pkg::time_type now;
   logic              request_valid;
   logic              want_cover;
   cas_pkg::code_type request_code;

   modport source (output valid, now, request_valid, want_cover, request_code, input ready);
   modport sink   (input valid, now, request_valid, want_cover, request_code, output ready);
endinterface
`default_nettype wire

// ===== rtl/cas_rsp_if.sv =====
// result channel of the cover actuator power sequencer
`timescale 1ns / 1ps
`default_nettype none
interface cas_rsp_if;
   logic                    valid;
   logic                    ready;
   logic                    power_on;
   cas_pkg::status_type     cover_status;
   cas_pkg::phase_code_type phase;

   modport source (output valid, power_on, cover_status, phase, input ready);
   modport sink   (input valid, power_on, cover_status, phase, output ready);
endinterface
`default_nettype wire

// ===== rtl/cas_csr.sv =====
// configuration register bank
`timescale 1ns / 1ps
`default_nettype none
module cas_csr (
   input  wire  logic                   clock,
   input  wire  logic                   reset,
   input  wire  logic                   csr_wr_en,
   input  wire  cas_pkg::csr_index_type csr_index,
   input  wire  cas_pkg::csr_data_type  csr_wdata,
   output cas_pkg::cfg_type             cfg
);

   cas_pkg::cfg_type cfg_ff;
   cas_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            cas_pkg::CSR_REST_TIME:    cfg_in.rest_time    = csr_wdata;
            cas_pkg::CSR_UNCOVER_TIME: cfg_in.uncover_time = csr_wdata;
            cas_pkg::CSR_COVER_TIME:   cfg_in.cover_time   = csr_wdata;
            cas_pkg::CSR_MOVE_TIME:    cfg_in.move_time    = csr_wdata;
            cas_pkg::CSR_COVER_CODE:   cfg_in.cover_code   = csr_wdata[15:0];
            cas_pkg::CSR_UNCOVER_CODE: cfg_in.uncover_code = csr_wdata[15:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rest_time    <= cas_pkg::REST_TIME_RESET;
         cfg_ff.uncover_time <= cas_pkg::UNCOVER_TIME_RESET;
         cfg_ff.cover_time   <= cas_pkg::COVER_TIME_RESET;
         cfg_ff.move_time    <= cas_pkg::MOVE_TIME_RESET;
         cfg_ff.cover_code   <= cas_pkg::CODE_RESET;
         cfg_ff.uncover_code <= cas_pkg::CODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== rtl/cas_core.sv =====
// sequencer state and per-poll next-state logic
`timescale 1ns / 1ps
`default_nettype none
module cas_core (
   input  wire  logic                  clock,
   input  wire  logic                  reset,
   input  wire  logic                  fire,
   input  wire  cas_pkg::req_item_type item,
   input  wire  cas_pkg::cfg_type      cfg,
   output cas_pkg::rsp_item_type       result
);

   cas_pkg::phase_type  phase_ff,     phase_in;
   logic                dir_cover_ff, dir_cover_in;
   cas_pkg::time_type   deadline_ff,  deadline_in;
   logic                power_ff,     power_in;
   cas_pkg::status_type status_ff,    status_in;

   logic              code_ok;
   logic              busy;
   logic              take;
   logic              expired;
   cas_pkg::time_type diff;
   cas_pkg::dur_type  drive_time;

   assign code_ok    = item.want_cover ? (item.request_code == cfg.cover_code)
                                       : (item.request_code == cfg.uncover_code);
   assign busy       = (phase_ff != cas_pkg::PHASE_IDLE);
   assign take       = item.request_valid && code_ok && (!busy || (dir_cover_ff != item.want_cover));
   // wrapping signed difference, strictly later
   assign diff       = item.now - deadline_ff;
   assign expired    = busy && (diff != 32'd0) && !diff[31];
   assign drive_time = dir_cover_ff ? cfg.cover_time : cfg.uncover_time;

   // a taken request never expires in the same poll: the take branch has priority over expiry
   always_comb begin
      phase_in     = phase_ff;
      dir_cover_in = dir_cover_ff;
      deadline_in  = deadline_ff;
      power_in     = power_ff;
      status_in    = status_ff;
      if (take) begin
         power_in     = 1'b0;
         dir_cover_in = item.want_cover;
         status_in    = item.want_cover ? cas_pkg::STATUS_CLOSING : cas_pkg::STATUS_OPENING;
         phase_in     = cas_pkg::PHASE_REST1;
         deadline_in  = item.now + {1'b0, cfg.rest_time};
      end else if (expired) begin
         case (phase_ff)
            cas_pkg::PHASE_REST1: begin
               power_in    = 1'b1;
               phase_in    = cas_pkg::PHASE_DRIVE;
               deadline_in = deadline_ff + {1'b0, drive_time};
            end
            cas_pkg::PHASE_DRIVE: begin
               power_in    = 1'b0;
               phase_in    = cas_pkg::PHASE_REST2;
               deadline_in = deadline_ff + {1'b0, cfg.rest_time};
            end
            cas_pkg::PHASE_REST2: begin
               power_in    = 1'b1;
               phase_in    = cas_pkg::PHASE_MOVE;
               deadline_in = deadline_ff + {1'b0, cfg.move_time};
            end
            cas_pkg::PHASE_MOVE: begin
               power_in  = 1'b0;
               phase_in  = cas_pkg::PHASE_IDLE;
               status_in = dir_cover_ff ? cas_pkg::STATUS_CLOSED : cas_pkg::STATUS_OPENED;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= cas_pkg::PHASE_IDLE;
         dir_cover_ff <= 1'b0;
         deadline_ff  <= 32'd0;
         power_ff     <= 1'b0;
         status_ff    <= cas_pkg::STATUS_UNKNOWN;
      end else if (fire) begin
         phase_ff     <= phase_in;
         dir_cover_ff <= dir_cover_in;
         deadline_ff  <= deadline_in;
         power_ff     <= power_in;
         status_ff    <= status_in;
      end
   end

   assign result.power_on     = power_in;
   assign result.cover_status = status_in;
   assign result.phase        = cas_pkg::phase_code(phase_in);

endmodule
`default_nettype wire

// ===== rtl/cover_actuator_power_sequencer.sv =====
// Cover actuator power sequencer. Every request is one poll: it carries the free-running time
// count and optionally a cover or uncover command with a safety code, and gives exactly one
// result holding power, cover status and phase as they stand after that poll. A command whose
// code matches the register for its direction is taken when the sequencer is idle or when it
// reverses the running direction; it drops power and starts the first rest. The sequence then
// runs first rest (off), drive (on), second rest (off), move (on), idle. Each phase ends on the
// first poll strictly later than its deadline, compared as a wrapping signed 32-bit difference,
// and each new deadline adds to the previous one. Throughput is one request per clock while the
// receiver keeps up: the request is held in an input register, the whole poll (two code
// compares, one 32-bit subtract for the deadline check, one 32-bit add for the next deadline)
// is a single pass of logic; polling writes the result into an output register, which frees
// the input side, so a request is taken while a result waits. The user writes configuration
// registers through the csr port only while no request is in flight; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none
`include "cover_actuator_power_sequencer_assert.svh"
module cover_actuator_power_sequencer (
   input  wire  logic                   clock,
   input  wire  logic                   reset,
   cas_req_if.sink                      req_chan,
   cas_rsp_if.source                    rsp_chan,
   input  wire  logic                   csr_wr_en,
   input  wire  cas_pkg::csr_index_type csr_index,
   input  wire  cas_pkg::csr_data_type  csr_wdata
);

   // configuration registers
   cas_pkg::cfg_type cfg;

   // input register
   cas_pkg::req_item_type req_item_ff, req_item_in;
   logic                  req_full_ff, req_full_in;

   // result register
   cas_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   logic                  rsp_full_ff, rsp_full_in;

   cas_pkg::rsp_item_type result;
   logic                  req_take;
   logic                  fire;

   cas_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // poll the held request when the result register is free or being emptied
   assign fire     = req_full_ff && (!rsp_full_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !req_full_ff || fire;

   cas_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (req_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // input register next values
   always_comb begin
      req_item_in = req_item_ff;
      if (req_take) begin
         req_item_in.now           = req_chan.now;
         req_item_in.request_valid = req_chan.request_valid;
         req_item_in.want_cover    = req_chan.want_cover;
         req_item_in.request_code  = req_chan.request_code;
      end
   end

   assign req_full_in = req_take ? 1'b1 : (fire ? 1'b0 : req_full_ff);

   // result register next values
   assign rsp_item_in = fire ? result : rsp_item_ff;
   assign rsp_full_in = fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_full_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_full_ff <= 1'b0;
         rsp_full_ff <= 1'b0;
      end else begin
         req_full_ff <= req_full_in;
         rsp_full_ff <= rsp_full_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      req_item_ff <= req_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_chan.valid        = rsp_full_ff;
   assign rsp_chan.power_on     = rsp_item_ff.power_on;
   assign rsp_chan.cover_status = rsp_item_ff.cover_status;
   assign rsp_chan.phase        = rsp_item_ff.phase;

   // power is only ever on while driving or moving
   `CAS_ASSERT_IMPLY(a_power_phase, clock, reset, rsp_full_ff && rsp_item_ff.power_on, (rsp_item_ff.phase == cas_pkg::PHASE_CODE_DRIVE) || (rsp_item_ff.phase == cas_pkg::PHASE_CODE_MOVE))
   // a held request that is not polled stays held
   `CAS_ASSERT_NEXT(a_req_kept, clock, reset, req_full_ff && !fire, req_full_ff)
   // every poll leaves a result waiting
   `CAS_ASSERT_NEXT(a_poll_result, clock, reset, fire, rsp_full_ff)

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// self-checking testbench for the cover actuator power sequencer
`timescale 1ns / 1ps
module tb;

   // run limits
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 100;
   localparam int REPORT_CAP  = 40;
   localparam int PHASE_POLLS = 110;

   // register indexes past the last real one, writes there must do nothing
   localparam cas_pkg::csr_index_type CSR_SPARE_6 = 3'd6;
   localparam cas_pkg::csr_index_type CSR_SPARE_7 = 3'd7;

   localparam logic PINNED = 1'b1;
   localparam logic FREE   = 1'b0;

   typedef enum logic {ROW_POLL, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE} rx_mode_type;

   // one line of the directed script: either a poll or a register write
   typedef struct packed {
      row_kind_type           kind;
      cas_pkg::req_item_type  poll;
      logic                   pinned;
      cas_pkg::rsp_item_type  report;
      cas_pkg::csr_index_type idx;
      cas_pkg::csr_data_type  data;
   } script_row_type;

   // a hand-typed report travels with its request, else the model decides
   typedef struct packed {
      logic                  pinned;
      cas_pkg::rsp_item_type report;
   } pin_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   cas_pkg::csr_index_type csr_index;
   cas_pkg::csr_data_type  csr_wdata;

   cas_req_if req_if ();
   cas_rsp_if rsp_if ();

   cover_actuator_power_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // sequencer model: timing registers, safety codes and phase state
   // ---------------------------------------------------------------
   cas_pkg::dur_type        rest_dur    = cas_pkg::REST_TIME_RESET;
   cas_pkg::dur_type        uncover_dur = cas_pkg::UNCOVER_TIME_RESET;
   cas_pkg::dur_type        cover_dur   = cas_pkg::COVER_TIME_RESET;
   cas_pkg::dur_type        move_dur    = cas_pkg::MOVE_TIME_RESET;
   cas_pkg::code_type       cover_key   = cas_pkg::CODE_RESET;
   cas_pkg::code_type       uncover_key = cas_pkg::CODE_RESET;
   cas_pkg::phase_code_type seq_ph      = cas_pkg::PHASE_CODE_IDLE;
   logic                    dir_cover   = 1'b0;
   cas_pkg::time_type       due_time    = '0;
   logic                    power_q     = 1'b0;
   cas_pkg::status_type     status_q    = cas_pkg::STATUS_UNKNOWN;

   // expected power/status/phase reports, oldest first
   cas_pkg::rsp_item_type state_reports_q[$];
   pin_type               pin_q[$];
   script_row_type        script_q[$];

   int                int_dummy_unused_guard;
   int                polls_sent   = 0;
   int                results_seen = 0;
   int                mismatches   = 0;
   int                cycles_run   = 0;
   int                burst_left   = 0;
   bit                hold_wanted  = 1'b0;
   bit                hold_done    = 1'b0;
   cas_pkg::time_type poll_clock   = '0;

   // strictly later, wrapping: a difference of zero or of exactly 2^31 is not later
   function automatic bit is_past(cas_pkg::time_type t, cas_pkg::time_type due);
      cas_pkg::time_type d;
      d = t - due;
      return (d != '0) && !d[31];
   endfunction

   // one poll: take the command first, then test the running phase with the same time
   function automatic cas_pkg::rsp_item_type poll_sequencer(cas_pkg::req_item_type p);
      cas_pkg::rsp_item_type r;
      logic                  key_ok;
      if (p.request_valid) begin
         key_ok = p.want_cover ? (p.request_code == cover_key)
                               : (p.request_code == uncover_key);
         // taken when idle or when it turns the actuator round
         if (key_ok && (seq_ph == cas_pkg::PHASE_CODE_IDLE || dir_cover != p.want_cover)) begin
            power_q   = 1'b0;
            dir_cover = p.want_cover;
            status_q  = p.want_cover ? cas_pkg::STATUS_CLOSING : cas_pkg::STATUS_OPENING;
            seq_ph    = cas_pkg::PHASE_CODE_REST1;
            due_time  = p.now + cas_pkg::time_type'(rest_dur);
         end
      end
      if (seq_ph != cas_pkg::PHASE_CODE_IDLE && is_past(p.now, due_time)) begin
         case (seq_ph)
            cas_pkg::PHASE_CODE_REST1: begin
               power_q  = 1'b1;
               seq_ph   = cas_pkg::PHASE_CODE_DRIVE;
               due_time = due_time
                          + cas_pkg::time_type'(dir_cover ? cover_dur : uncover_dur);
            end
            cas_pkg::PHASE_CODE_DRIVE: begin
               power_q  = 1'b0;
               seq_ph   = cas_pkg::PHASE_CODE_REST2;
               due_time = due_time + cas_pkg::time_type'(rest_dur);
            end
            cas_pkg::PHASE_CODE_REST2: begin
               power_q  = 1'b1;
               seq_ph   = cas_pkg::PHASE_CODE_MOVE;
               due_time = due_time + cas_pkg::time_type'(move_dur);
            end
            default: begin
               power_q  = 1'b0;
               seq_ph   = cas_pkg::PHASE_CODE_IDLE;
               status_q = dir_cover ? cas_pkg::STATUS_CLOSED : cas_pkg::STATUS_OPENED;
            end
         endcase
      end
      r.power_on     = power_q;
      r.cover_status = status_q;
      r.phase        = seq_ph;
      return r;
   endfunction

   // codes keep only their low 16 bits, unknown indexes are dropped
   function automatic void apply_register(cas_pkg::csr_index_type idx,
                                          cas_pkg::csr_data_type data);
      case (idx)
         cas_pkg::CSR_REST_TIME:    rest_dur    = data;
         cas_pkg::CSR_UNCOVER_TIME: uncover_dur = data;
         cas_pkg::CSR_COVER_TIME:   cover_dur   = data;
         cas_pkg::CSR_MOVE_TIME:    move_dur    = data;
         cas_pkg::CSR_COVER_CODE:   cover_key   = data[15:0];
         cas_pkg::CSR_UNCOVER_CODE: uncover_key = data[15:0];
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= REPORT_CAP)
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   // ---------------------------------------------------------------
   // monitor: register writes and accepted requests feed the model,
   // every accepted result is held against the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin : monitor
      cas_pkg::req_item_type p;
      cas_pkg::rsp_item_type want;
      cas_pkg::rsp_item_type got;
      pin_type               pin;
      if (!reset) begin
         if (csr_wr_en)
            apply_register(csr_index, csr_wdata);
         if (req_if.valid && req_if.ready) begin
            p.now           = req_if.now;
            p.request_valid = req_if.request_valid;
            p.want_cover    = req_if.want_cover;
            p.request_code  = req_if.request_code;
            want            = poll_sequencer(p);
            pin             = '0;
            if (pin_q.size() != 0)
               pin = pin_q.pop_front();
            state_reports_q.push_back(pin.pinned ? pin.report : want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            got.power_on     = rsp_if.power_on;
            got.cover_status = rsp_if.cover_status;
            got.phase        = rsp_if.phase;
            if (state_reports_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_CAP)
                  $display("%0t: result expected none actual %0d/%0d/%0d", $time,
                           got.power_on, got.cover_status, got.phase);
            end else begin
               want = state_reports_q.pop_front();
               check_field("power_on", want.power_on, got.power_on);
               check_field("cover_status", want.cover_status, got.cover_status);
               check_field("phase", want.phase, got.phase);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (cycles_run == CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // receiver: stretches of steady, coin-toss and sparse readiness,
   // plus one long hold-off so the block backs up into its input
   // ---------------------------------------------------------------
   initial begin : receiver
      rx_mode_type mode;
      int          span;
      forever begin
         mode = rx_mode_type'($urandom_range(0, 2));
         span = $urandom_range(4, 40);
         for (int i = 0; i < span; i++) begin
            if (hold_wanted && !hold_done)
               break;
            case (mode)
               RX_STEADY: rsp_if.ready <= 1'b1;
               RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
               default:   rsp_if.ready <= (i % 4 == 3);
            endcase
            @(posedge clock);
         end
         if (hold_wanted && !hold_done) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------
   function automatic cas_pkg::rsp_item_type report_of(logic power, cas_pkg::status_type st,
                                                       cas_pkg::phase_code_type ph);
      cas_pkg::rsp_item_type r;
      r.power_on     = power;
      r.cover_status = st;
      r.phase        = ph;
      return r;
   endfunction

   function automatic void add_poll(cas_pkg::time_type now, logic rv, logic wc,
                                    cas_pkg::code_type code, logic pinned,
                                    cas_pkg::rsp_item_type report);
      script_row_type row;
      row                    = '0;
      row.kind               = ROW_POLL;
      row.poll.now           = now;
      row.poll.request_valid = rv;
      row.poll.want_cover    = wc;
      row.poll.request_code  = code;
      row.pinned             = pinned;
      row.report             = report;
      script_q.push_back(row);
   endfunction

   function automatic void add_write(cas_pkg::csr_index_type idx, cas_pkg::csr_data_type data);
      script_row_type row;
      row      = '0;
      row.kind = ROW_CSR;
      row.idx  = idx;
      row.data = data;
      script_q.push_back(row);
   endfunction

   // random poll: time mostly creeps forward, now and then it jumps anywhere
   function automatic cas_pkg::req_item_type next_poll(cas_pkg::time_type step_max);
      cas_pkg::req_item_type p;
      if ($urandom_range(0, 39) == 0)
         poll_clock = $urandom;
      else
         poll_clock = poll_clock + $urandom_range(0, step_max);
      p.now           = poll_clock;
      p.request_valid = ($urandom_range(0, 9) == 0);
      p.want_cover    = 1'($urandom_range(0, 1));
      if (p.request_valid && $urandom_range(0, 3) != 0)
         p.request_code = p.want_cover ? cover_key : uncover_key;
      else
         p.request_code = cas_pkg::code_type'($urandom);
      return p;
   endfunction

   // bursts of back-to-back requests separated by short gaps
   task automatic offer_poll(cas_pkg::req_item_type p, logic pinned,
                             cas_pkg::rsp_item_type report);
      pin_type pin;
      csr_wr_en <= 1'b0;
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      pin.pinned = pinned;
      pin.report = report;
      pin_q.push_back(pin);
      req_if.valid         <= 1'b1;
      req_if.now           <= p.now;
      req_if.request_valid <= p.request_valid;
      req_if.want_cover    <= p.want_cover;
      req_if.request_code  <= p.request_code;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      polls_sent++;
   endtask

   task automatic write_csr(cas_pkg::csr_index_type idx, cas_pkg::csr_data_type data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // every request answered, nothing left inside the block
   task automatic wait_for_reports();
      while (results_seen != polls_sent) @(posedge clock);
   endtask

   task automatic load_timing(cas_pkg::dur_type rest, cas_pkg::dur_type unc,
                              cas_pkg::dur_type cov, cas_pkg::dur_type mov,
                              cas_pkg::csr_data_type ck, cas_pkg::csr_data_type uk);
      req_if.valid <= 1'b0;
      wait_for_reports();
      write_csr(cas_pkg::CSR_REST_TIME, rest);
      write_csr(cas_pkg::CSR_UNCOVER_TIME, unc);
      write_csr(cas_pkg::CSR_COVER_TIME, cov);
      write_csr(cas_pkg::CSR_MOVE_TIME, mov);
      write_csr(cas_pkg::CSR_COVER_CODE, ck);
      write_csr(cas_pkg::CSR_UNCOVER_CODE, uk);
   endtask

   task automatic run_phase(int count, cas_pkg::time_type step_max);
      for (int n = 0; n < count; n++)
         offer_poll(next_poll(step_max), FREE, '0);
   endtask

   initial begin : stimulus
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_index            <= '0;
      csr_wdata            <= '0;
      req_if.valid         <= 1'b0;
      req_if.now           <= '0;
      req_if.request_valid <= 1'b0;
      req_if.want_cover    <= 1'b0;
      req_if.request_code  <= '0;

      // --- directed script, reset timing: rest 2M, uncover 4M, cover 8M, move 45M ---
      // quiet poll straight after reset
      add_poll(32'd0, 1'b0, 1'b0, 16'h0000, PINNED,
               report_of(1'b0, cas_pkg::STATUS_UNKNOWN, cas_pkg::PHASE_CODE_IDLE));
      // wrong codes in both directions are ignored
      add_poll(32'd5, 1'b1, 1'b1, 16'hFFFF, PINNED,
               report_of(1'b0, cas_pkg::STATUS_UNKNOWN, cas_pkg::PHASE_CODE_IDLE));
      add_poll(32'd6, 1'b1, 1'b0, 16'h8001, PINNED,
               report_of(1'b0, cas_pkg::STATUS_UNKNOWN, cas_pkg::PHASE_CODE_IDLE));
      // cover accepted from idle
      add_poll(32'd10, 1'b1, 1'b1, 16'h0000, PINNED,
               report_of(1'b0, cas_pkg::STATUS_CLOSING, cas_pkg::PHASE_CODE_REST1));
      // exactly at the deadline is not yet later
      add_poll(32'd2000010, 1'b0, 1'b0, 16'h0000, PINNED,
               report_of(1'b0, cas_pkg::STATUS_CLOSING, cas_pkg::PHASE_CODE_REST1));
      add_poll(32'd2000011, 1'b0, 1'b0, 16'h0000, PINNED,
               report_of(1'b1, cas_pkg::STATUS_CLOSING, cas_pkg::PHASE_CODE_DRIVE));
      // same direction while busy changes nothing
      add_poll(32'd2000012, 1'b1, 1'b1, 16'h0000, PINNED,
               report_of(1'b1, cas_pkg::STATUS_CLOSING, cas_pkg::PHASE_CODE_DRIVE));
      // reversal restarts the first rest, deadline now 4000013
      add_poll(32'd2000013, 1'b1, 1'b0, 16'h0000, PINNED,
               report_of(1'b0, cas_pkg::STATUS_OPENING, cas_pkg::PHASE_CODE_REST1));
      // difference of exactly 2^31 counts as not later
      add_poll(32'h803D090D, 1'b0, 1'b0, 16'h0000, PINNED,
               report_of(1'b0, cas_pkg::STATUS_OPENING, cas_pkg::PHASE_CODE_REST1));
      add_poll(32'd4000014, 1'b0, 1'b0, 16'h0000, FREE, '0);
      add_poll(32'd8000015, 1'b0, 1'b0, 16'h0000, FREE, '0);
      add_poll(32'd10000016, 1'b0, 1'b0, 16'h0000, FREE, '0);
      add_poll(32'd55000014, 1'b0, 1'b0, 16'h0000, PINNED,
               report_of(1'b0, cas_pkg::STATUS_OPENED, cas_pkg::PHASE_CODE_IDLE));
      // deadline wraps past the top of the count
      add_poll(32'hFFFFFFFF, 1'b1, 1'b1, 16'h0000, FREE, '0);
      add_poll(32'd0, 1'b0, 1'b0, 16'h0000, FREE, '0);
      add_poll(32'd2000000, 1'b0, 1'b0, 16'h0000, FREE, '0);
      // extreme timing, codes with junk above bit 15, writes to spare indexes
      add_write(cas_pkg::CSR_REST_TIME, 31'h0);
      add_write(cas_pkg::CSR_UNCOVER_TIME, 31'h0);
      add_write(cas_pkg::CSR_COVER_TIME, 31'h7FFFFFFF);
      add_write(cas_pkg::CSR_MOVE_TIME, 31'h7FFFFFFF);
      add_write(cas_pkg::CSR_COVER_CODE, 31'h7FFFA5C3);
      add_write(cas_pkg::CSR_UNCOVER_CODE, 31'h00005A3C);
      add_write(CSR_SPARE_6, 31'h7FFFFFFF);
      add_write(CSR_SPARE_7, 31'h12345678);
      // zero-length phases each end one poll later
      add_poll(32'd100, 1'b1, 1'b0, 16'h5A3C, PINNED,
               report_of(1'b0, cas_pkg::STATUS_OPENING, cas_pkg::PHASE_CODE_REST1));
      add_poll(32'd101, 1'b0, 1'b0, 16'h0000, FREE, '0);
      add_poll(32'd101, 1'b0, 1'b0, 16'h0000, FREE, '0);
      add_poll(32'd102, 1'b0, 1'b0, 16'h0000, FREE, '0);
      // longest move: equal is not later, one past it finishes
      add_poll(32'h80000063, 1'b0, 1'b0, 16'h0000, FREE, '0);
      add_poll(32'h80000064, 1'b0, 1'b0, 16'h0000, PINNED,
               report_of(1'b0, cas_pkg::STATUS_OPENED, cas_pkg::PHASE_CODE_IDLE));
      add_poll(32'd5, 1'b1, 1'b1, 16'hA5C3, PINNED,
               report_of(1'b0, cas_pkg::STATUS_CLOSING, cas_pkg::PHASE_CODE_REST1));
      add_poll(32'd6, 1'b0, 1'b0, 16'h0000, FREE, '0);
      // reversal with a code one off is refused
      add_poll(32'd7, 1'b1, 1'b0, 16'h5A3D, FREE, '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (script_q[i]) begin
         if (script_q[i].kind == ROW_CSR) begin
            req_if.valid <= 1'b0;
            wait_for_reports();
            write_csr(script_q[i].idx, script_q[i].data);
         end else begin
            offer_poll(script_q[i].poll, script_q[i].pinned, script_q[i].report);
         end
      end

      // --- random part ---
      // short timing so whole sequences run; opens with a long gapless burst
      // while the receiver holds off
      load_timing(cas_pkg::dur_type'($urandom_range(0, 20)),
                  cas_pkg::dur_type'($urandom_range(0, 20)),
                  cas_pkg::dur_type'($urandom_range(0, 20)),
                  cas_pkg::dur_type'($urandom_range(0, 20)),
                  cas_pkg::csr_data_type'($urandom), cas_pkg::csr_data_type'($urandom));
      hold_wanted = 1'b1;
      burst_left  = 60;
      run_phase(PHASE_POLLS, 32'd8);

      // every duration zero, codes at both ends of their range
      load_timing(31'h0, 31'h0, 31'h0, 31'h0, 31'h0, 31'h7FFFFFFF);
      run_phase(PHASE_POLLS, 32'd2);

      // every duration at its maximum, time moves in large strides
      load_timing(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
                  cas_pkg::csr_data_type'($urandom), cas_pkg::csr_data_type'($urandom));
      run_phase(PHASE_POLLS, 32'h40000000);

      // mid-range timing
      load_timing(cas_pkg::dur_type'($urandom_range(1, 1000)),
                  cas_pkg::dur_type'($urandom_range(1, 1000)),
                  cas_pkg::dur_type'($urandom_range(1, 1000)),
                  cas_pkg::dur_type'($urandom_range(1, 1000)),
                  cas_pkg::csr_data_type'($urandom), cas_pkg::csr_data_type'($urandom));
      run_phase(PHASE_POLLS, 32'd400);

      // anything goes
      load_timing(cas_pkg::dur_type'($urandom), cas_pkg::dur_type'($urandom),
                  cas_pkg::dur_type'($urandom), cas_pkg::dur_type'($urandom),
                  cas_pkg::csr_data_type'($urandom), cas_pkg::csr_data_type'($urandom));
      run_phase(PHASE_POLLS, 32'hFFFFFFFF);

      // drain, then leave room for any stray result
      req_if.valid <= 1'b0;
      wait_for_reports();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && state_reports_q.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
